>>> rtl/bfa_pkg.sv
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared types and constants of the bitmap first-fit allocator: map codes,
// map word patterns, command and status codes, controller states and the
// per-word scan summary.
// ----------------------------------------------------------------------------
package bfa_pkg;

    // default heap size is 2^HEAP_ORDER_DEF bytes
    localparam int HEAP_ORDER_DEF = 16;

    // transaction field widths
    localparam int REQ_BYTES_W = 17;
    localparam int OFFSET_W    = 16;

    // unit count of a request: up to (2^17 - 1 + 15) / 16 = 8192
    localparam int NEED_W = 14;

    // two-bit unit codes
    localparam logic [1:0] CODE_FREE = 2'b11;
    localparam logic [1:0] CODE_HEAD = 2'b01;
    localparam logic [1:0] CODE_BODY = 2'b00;

    // map word patterns used by the post-reset fill
    localparam logic [31:0] WORD_HEAD = 32'h4000_0000;
    localparam logic [31:0] WORD_BODY = 32'h0000_0000;
    localparam logic [31:0] WORD_FREE = 32'hFFFF_FFFF;

    // commands
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // result status
    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_NO_SPACE = 1'b1;

    // controller states
    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_SCAN,
        ST_MARK,
        ST_FREE,
        ST_DONE
    } state_t;

    // summary of one map word during the first-fit search
    typedef struct packed {
        logic       found;      // run completes in this word
        logic       use_carry;  // run started in an earlier word
        logic [3:0] head_pos;   // first unit of a run found inside the word
        logic [3:0] tail_pos;   // last unit of the run
        logic       all_free;   // every unit of the word is free
        logic [4:0] trail_cnt;  // free units at the end of the word
    } scan_res_t;

endpackage

>>> rtl/bfa_req_if.sv
// ----------------------------------------------------------------------------
// bfa_req_if
// Request channel of the allocator: command, byte count and offset to free.
// ----------------------------------------------------------------------------
interface bfa_req_if;

    logic                               valid;
    logic                               ready;
    logic                               command;
    logic [bfa_pkg::REQ_BYTES_W-1:0]    request_bytes;
    logic [bfa_pkg::OFFSET_W-1:0]       free_offset;

    modport source (
        output valid, command, request_bytes, free_offset,
        input  ready
    );

    modport sink (
        input  valid, command, request_bytes, free_offset,
        output ready
    );

endinterface

>>> rtl/bfa_rsp_if.sv
// ----------------------------------------------------------------------------
// bfa_rsp_if
// Response channel of the allocator: status and allocated offset.
// ----------------------------------------------------------------------------
interface bfa_rsp_if;

    logic                           valid;
    logic                           ready;
    logic                           status;
    logic [bfa_pkg::OFFSET_W-1:0]   alloc_offset;

    modport source (
        output valid, status, alloc_offset,
        input  ready
    );

    modport sink (
        input  valid, status, alloc_offset,
        output ready
    );

endinterface

>>> rtl/bfa_ram.sv
// ----------------------------------------------------------------------------
// bfa_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. No reset on the array.
// ----------------------------------------------------------------------------
module bfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [$clog2(DEPTH)-1:0]    wr_addr,
    input  logic [WIDTH-1:0]            wr_data,
    input  logic                        rd_en,
    input  logic [$clog2(DEPTH)-1:0]    rd_addr,
    output logic [WIDTH-1:0]            rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> rtl/bfa_word_scan.sv
// ----------------------------------------------------------------------------
// bfa_word_scan
// First-fit analysis of one map word: extends a run carried in from earlier
// words, looks for a run that fits inside the word, and reports the free
// tail that carries into the next word.
// ----------------------------------------------------------------------------
module bfa_word_scan (
    input  logic [31:0]                 word,
    input  logic [bfa_pkg::NEED_W-1:0]  need,
    input  logic [15:0]                 need_mask,
    input  logic                        need_small,
    input  logic [bfa_pkg::NEED_W-1:0]  streak,
    output bfa_pkg::scan_res_t          res
);

    import bfa_pkg::*;

    localparam int SUM_W = NEED_W + 1;

    logic [15:0]        free_vec;   // bit i set: unit i (msb pair is unit 0) free
    logic [4:0]         lead_cnt;
    logic [4:0]         trail_cnt;
    logic [15:0]        win_ok;
    logic [3:0]         head_pos;
    logic               carry_hit;
    logic [NEED_W-1:0]  carry_left;
    logic [4:0]         win_tail;

    // free flags and leading/trailing free counts
    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            free_vec[i] = word[31-2*i] & word[30-2*i];
        end
        lead_cnt = 5'd16;
        for (int i = 15; i >= 0; i--)
        begin
            if (!free_vec[i])
            begin
                lead_cnt = 5'(i);
            end
        end
        trail_cnt = 5'd16;
        for (int i = 0; i < 16; i++)
        begin
            if (!free_vec[i])
            begin
                trail_cnt = 5'(15 - i);
            end
        end
    end

    // in-word window match at every start position, first one wins
    always_comb
    begin
        logic [31:0] sh;
        sh = 32'd0;
        for (int p = 0; p < 16; p++)
        begin
            sh = 32'(need_mask) << p;
            win_ok[p] = need_small && (sh[31:16] == 16'd0) &&
                        ((free_vec & sh[15:0]) == sh[15:0]);
        end
        head_pos = 4'd0;
        for (int p = 15; p >= 0; p--)
        begin
            if (win_ok[p])
            begin
                head_pos = 4'(p);
            end
        end
    end

    // completion of a run carried in from the previous words
    assign carry_hit  = (streak != '0) &&
                        ((SUM_W'(streak) + SUM_W'(lead_cnt)) >= SUM_W'(need));
    assign carry_left = need - streak - NEED_W'(1);
    assign win_tail   = 5'(head_pos) + need[4:0] - 5'd1;

    // summary
    always_comb
    begin
        res.found     = carry_hit || (win_ok != 16'd0);
        res.use_carry = carry_hit;
        res.head_pos  = head_pos;
        res.tail_pos  = carry_hit ? carry_left[3:0] : win_tail[3:0];
        res.all_free  = (free_vec == 16'hFFFF);
        res.trail_cnt = trail_cnt;
    end

endmodule

>>> rtl/bitmap_first_fit_allocator_core.sv
// ----------------------------------------------------------------------------
// bitmap_first_fit_allocator_core
// First-fit heap allocator over a two-bit-per-unit map held in one RAM.
// ----------------------------------------------------------------------------
// The heap of 2^HEAP_ORDER bytes is tracked in 16-byte units, sixteen units
// to a 32-bit map word, in a RAM of 2^(HEAP_ORDER-8) words. After reset the
// block fills the map (map area and 256-byte reserved block allocated, rest
// free), one word per cycle, and accepts nothing until the fill is done.
// One transaction is worked at a time, and the RAM read port moving one
// word per cycle sets the pace. An allocate reads each map word from the
// word after the reserved block up to the word where the run completes (at
// most 2^(HEAP_ORDER-8) - 2^(HEAP_ORDER-14) - 1 words), then rewrites each
// word the new block covers; a zero size is answered without a scan. A free
// rewrites each map word it visits, from the addressed one onward.
// Results go to an output register, so the next request is taken while a
// result still waits. Allocate returns status 0 and the byte offset (low 16
// bits), or status 1 and offset 0; free always returns status 0, offset 0.
// ----------------------------------------------------------------------------
module bitmap_first_fit_allocator_core #(
    parameter int HEAP_ORDER = bfa_pkg::HEAP_ORDER_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    bfa_req_if.sink         req,
    bfa_rsp_if.source       rsp
);

    import bfa_pkg::*;

    localparam int UW        = HEAP_ORDER - 4;          // unit index width
    localparam int AW        = HEAP_ORDER - 8;          // map word index width
    localparam int MAP_WORDS = 1 << AW;
    localparam int RES_WORD  = 1 << (HEAP_ORDER - 14);

    localparam logic [AW-1:0] LAST_ADDR = AW'(MAP_WORDS - 1);
    localparam logic [AW-1:0] RES_ADDR  = AW'(RES_WORD);
    localparam logic [AW-1:0] SCAN_ADDR = AW'(RES_WORD + 1);

    // controller registers
    state_t             state_reg, state_next;
    logic [AW-1:0]      addr_reg, addr_next;            // next read address
    logic               issue_done_reg, issue_done_next;
    logic               dv_reg, dv_next;                // read data valid
    logic [AW-1:0]      dw_reg, dw_next;                // address of read data
    logic [NEED_W-1:0]  need_reg, need_next;
    logic [15:0]        nmask_reg, nmask_next;
    logic               need_small_reg, need_small_next;
    logic [NEED_W-1:0]  streak_reg, streak_next;
    logic [UW-1:0]      start_reg, start_next;
    logic [UW-1:0]      end_reg, end_next;
    logic               first_reg, first_next;
    logic               res_status_reg, res_status_next;
    logic [15:0]        res_offset_reg, res_offset_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_status_reg, out_status_next;
    logic [15:0]        out_offset_reg, out_offset_next;

    // map RAM ports
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [31:0]        wr_data;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic [31:0]        rd_data;

    // request decode and word-level helpers
    logic [17:0]        req_sum;
    logic [NEED_W-1:0]  req_need;
    logic [16:0]        req_mask;
    logic               free_in_heap;
    logic [AW-1:0]      issue_last;
    logic [31:0]        init_word;
    logic [31:0]        mark_word;
    logic [31:0]        free_word;
    logic [4:0]         free_stop;
    scan_res_t          scan_res;

    logic [AW-1:0]      start_word;
    logic [3:0]         start_pos;
    logic [AW-1:0]      end_word;
    logic [3:0]         end_pos;

    assign start_word = start_reg[UW-1:4];
    assign start_pos  = start_reg[3:0];
    assign end_word   = end_reg[UW-1:4];
    assign end_pos    = end_reg[3:0];

    // map storage
    bfa_ram #(
        .WIDTH (32),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // first-fit analysis of the word coming out of the RAM
    bfa_word_scan u_scan (
        .word       (rd_data),
        .need       (need_reg),
        .need_mask  (nmask_reg),
        .need_small (need_small_reg),
        .streak     (streak_reg),
        .res        (scan_res)
    );

    // request decode
    assign req_sum      = 18'(req.request_bytes) + 18'd15;
    assign req_need     = req_sum[17:4];
    assign req_mask     = (17'd1 << req_need[4:0]) - 17'd1;
    assign free_in_heap = ((32'(req.free_offset) >> HEAP_ORDER) == 32'd0);
    assign issue_last   = (state_reg == ST_MARK) ? end_word : LAST_ADDR;

    // reset pattern of the map
    always_comb
    begin
        if (addr_reg == '0 || addr_reg == RES_ADDR)
        begin
            init_word = WORD_HEAD;
        end
        else if (addr_reg < RES_ADDR)
        begin
            init_word = WORD_BODY;
        end
        else
        begin
            init_word = WORD_FREE;
        end
    end

    // mark a new block inside the word under write
    always_comb
    begin
        logic [3:0] lo;
        logic [3:0] hi;
        logic       head_here;
        lo        = (dw_reg == start_word) ? start_pos : 4'd0;
        hi        = (dw_reg == end_word) ? end_pos : 4'd15;
        head_here = (dw_reg == start_word);
        mark_word = rd_data;
        for (int i = 0; i < 16; i++)
        begin
            if (4'(i) >= lo && 4'(i) <= hi)
            begin
                if (head_here && 4'(i) == start_pos)
                begin
                    mark_word[31-2*i -: 2] = CODE_HEAD;
                end
                else
                begin
                    mark_word[31-2*i -: 2] = CODE_BODY;
                end
            end
        end
    end

    // release units: the addressed one, then continuation units that follow
    always_comb
    begin
        logic [3:0] p0;
        logic [4:0] cstart;
        p0        = first_reg ? start_pos : 4'd0;
        cstart    = first_reg ? (5'(start_pos) + 5'd1) : 5'd0;
        free_stop = 5'd16;
        for (int i = 15; i >= 0; i--)
        begin
            if (5'(i) >= cstart && rd_data[31-2*i -: 2] != CODE_BODY)
            begin
                free_stop = 5'(i);
            end
        end
        free_word = rd_data;
        for (int i = 0; i < 16; i++)
        begin
            if (4'(i) >= p0 && 5'(i) < free_stop)
            begin
                free_word[31-2*i -: 2] = CODE_FREE;
            end
        end
    end

    // state and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_INIT;
            addr_reg       <= '0;
            issue_done_reg <= 1'b0;
            dv_reg         <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            addr_reg       <= addr_next;
            issue_done_reg <= issue_done_next;
            dv_reg         <= dv_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        dw_reg         <= dw_next;
        need_reg       <= need_next;
        nmask_reg      <= nmask_next;
        need_small_reg <= need_small_next;
        streak_reg     <= streak_next;
        start_reg      <= start_next;
        end_reg        <= end_next;
        first_reg      <= first_next;
        res_status_reg <= res_status_next;
        res_offset_reg <= res_offset_next;
        out_status_reg <= out_status_next;
        out_offset_reg <= out_offset_next;
    end

    // next state and datapath control
    always_comb
    begin
        state_next      = state_reg;
        addr_next       = addr_reg;
        issue_done_next = issue_done_reg;
        dv_next         = 1'b0;
        dw_next         = dw_reg;
        need_next       = need_reg;
        nmask_next      = nmask_reg;
        need_small_next = need_small_reg;
        streak_next     = streak_reg;
        start_next      = start_reg;
        end_next        = end_reg;
        first_next      = first_reg;
        res_status_next = res_status_reg;
        res_offset_next = res_offset_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_offset_next = out_offset_reg;

        wr_en   = 1'b0;
        wr_addr = dw_reg;
        wr_data = rd_data;
        rd_en   = 1'b0;
        rd_addr = addr_reg;

        // output transaction taken
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        // read issue shared by the scan, mark and free phases
        if ((state_reg == ST_SCAN || state_reg == ST_MARK || state_reg == ST_FREE) &&
            !issue_done_reg)
        begin
            rd_en           = 1'b1;
            addr_next       = addr_reg + AW'(1);
            issue_done_next = (addr_reg == issue_last);
            dv_next         = 1'b1;
            dw_next         = addr_reg;
        end

        case (state_reg)
            ST_INIT:
            begin
                wr_en     = 1'b1;
                wr_addr   = addr_reg;
                wr_data   = init_word;
                addr_next = addr_reg + AW'(1);
                if (addr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (req.valid)
                begin
                    issue_done_next = 1'b0;
                    res_status_next = STATUS_OK;
                    res_offset_next = 16'd0;
                    if (req.command == CMD_ALLOC)
                    begin
                        need_next       = req_need;
                        nmask_next      = req_mask[15:0];
                        need_small_next = (req_need <= NEED_W'(16));
                        streak_next     = '0;
                        addr_next       = SCAN_ADDR;
                        if (req_need == '0)
                        begin
                            res_status_next = STATUS_NO_SPACE;
                            state_next      = ST_DONE;
                        end
                        else
                        begin
                            state_next = ST_SCAN;
                        end
                    end
                    else
                    begin
                        start_next = UW'(req.free_offset[15:4]);
                        addr_next  = AW'(req.free_offset[15:8]);
                        first_next = 1'b1;
                        if (free_in_heap)
                        begin
                            state_next = ST_FREE;
                        end
                        else
                        begin
                            state_next = ST_DONE;
                        end
                    end
                end
            end

            ST_SCAN:
            begin
                if (dv_reg)
                begin
                    if (scan_res.found)
                    begin
                        if (!scan_res.use_carry)
                        begin
                            start_next = {dw_reg, scan_res.head_pos};
                        end
                        end_next        = {dw_reg, scan_res.tail_pos};
                        addr_next       = scan_res.use_carry ? start_word : dw_reg;
                        issue_done_next = 1'b0;
                        dv_next         = 1'b0;
                        state_next      = ST_MARK;
                    end
                    else
                    begin
                        // carry the free tail of this word into the next one
                        if (scan_res.all_free)
                        begin
                            streak_next = streak_reg + NEED_W'(16);
                        end
                        else
                        begin
                            streak_next = NEED_W'(scan_res.trail_cnt);
                        end
                        if (!(scan_res.all_free && streak_reg != '0))
                        begin
                            start_next = {dw_reg, 4'(5'd16 - scan_res.trail_cnt)};
                        end
                        if (dw_reg == LAST_ADDR)
                        begin
                            res_status_next = STATUS_NO_SPACE;
                            res_offset_next = 16'd0;
                            state_next      = ST_DONE;
                        end
                    end
                end
            end

            ST_MARK:
            begin
                if (dv_reg)
                begin
                    wr_en   = 1'b1;
                    wr_data = mark_word;
                    if (dw_reg == end_word)
                    begin
                        res_status_next = STATUS_OK;
                        res_offset_next = 16'({start_reg, 4'b0000});
                        state_next      = ST_DONE;
                    end
                end
            end

            ST_FREE:
            begin
                if (dv_reg)
                begin
                    wr_en      = 1'b1;
                    wr_data    = free_word;
                    first_next = 1'b0;
                    if (free_stop != 5'd16 || dw_reg == LAST_ADDR)
                    begin
                        state_next = ST_DONE;
                    end
                end
            end

            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_offset_next = res_offset_reg;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // port drive
    assign req.ready        = (state_reg == ST_IDLE);
    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.alloc_offset = out_offset_reg;

    // the pipelined read-modify-write never reads the word being written
    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en && rd_en |-> wr_addr != rd_addr)
        else $error("map read and write hit the same word");

    // an open run is always shorter than the request while scanning
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> streak_reg < need_reg)
        else $error("scan carried a run that should have completed");

    // a new result only comes from the completion state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_DONE)
        else $error("result loaded outside the completion state");

endmodule

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the bitmap first-fit allocator core. A scoreboard
// class keeps its own copy of the unit map and predicts status and offset of
// every accepted allocate or free. Stimulus is a directed opening followed by
// random alloc/free traffic, with bursty requests and a stalling receiver.
// ----------------------------------------------------------------------------

// heap geometry, default build of the core
localparam int HEAP_ORDER     = bfa_pkg::HEAP_ORDER_DEF;
localparam int MAP_DEPTH      = 1 << (HEAP_ORDER - 8);
localparam int HEAP_UNITS     = 1 << (HEAP_ORDER - 4);
localparam int RESERVED_WORD  = 1 << (HEAP_ORDER - 14);
localparam int SCAN_FROM_UNIT = (RESERVED_WORD + 1) * 16;

typedef struct packed {
    logic                           status;
    logic [bfa_pkg::OFFSET_W-1:0]   offset;
} alloc_result_t;

class alloc_scoreboard;

    logic [31:0]    pair_map [MAP_DEPTH];
    alloc_result_t  pending_q [$];
    int             mismatches;
    int             results_seen;
    int             allocs_ok;
    int             allocs_refused;
    int             frees;

    // map state right after the post-reset fill
    function new();
        for (int w = 0; w < MAP_DEPTH; w++)
        begin
            if (w == 0 || w == RESERVED_WORD)
                pair_map[w] = bfa_pkg::WORD_HEAD;
            else if (w < RESERVED_WORD)
                pair_map[w] = bfa_pkg::WORD_BODY;
            else
                pair_map[w] = bfa_pkg::WORD_FREE;
        end
        mismatches     = 0;
        results_seen   = 0;
        allocs_ok      = 0;
        allocs_refused = 0;
        frees          = 0;
    endfunction

    // first unit of a word sits in the top pair
    function logic [1:0] unit_code(int u);
        return pair_map[u >> 4][30 - 2 * (u & 15) +: 2];
    endfunction

    function void set_unit(int u, logic [1:0] code);
        pair_map[u >> 4][30 - 2 * (u & 15) +: 2] = code;
    endfunction

    // predict the result of one accepted transaction and update the map
    function alloc_result_t note_request(logic cmd, logic [bfa_pkg::REQ_BYTES_W-1:0] bytes,
                                         logic [bfa_pkg::OFFSET_W-1:0] off);
        alloc_result_t  res;
        int             need;
        int             run;
        int             head;
        int             u;
        bit             hit;
        res.status = bfa_pkg::STATUS_OK;
        res.offset = '0;
        if (cmd == bfa_pkg::CMD_ALLOC)
        begin
            need = (int'(bytes) + 15) >> 4;
            run  = 0;
            head = 0;
            hit  = 1'b0;
            // first-fit search, runs may span map words
            if (need != 0)
            begin
                for (u = SCAN_FROM_UNIT; u < HEAP_UNITS && !hit; u++)
                begin
                    if (unit_code(u) == bfa_pkg::CODE_FREE)
                    begin
                        if (run == 0)
                            head = u;
                        run++;
                        if (run == need)
                            hit = 1'b1;
                    end
                    else
                        run = 0;
                end
            end
            if (hit)
            begin
                set_unit(head, bfa_pkg::CODE_HEAD);
                for (u = head + 1; u < head + need; u++)
                    set_unit(u, bfa_pkg::CODE_BODY);
                res.offset = 16'(head << 4);
                allocs_ok++;
            end
            else
            begin
                res.status = bfa_pkg::STATUS_NO_SPACE;
                allocs_refused++;
            end
        end
        else
        begin
            // addressed unit is freed whatever its code, then continuations
            u = int'(off) >> 4;
            if (u < HEAP_UNITS)
            begin
                set_unit(u, bfa_pkg::CODE_FREE);
                u++;
                while (u < HEAP_UNITS && unit_code(u) == bfa_pkg::CODE_BODY)
                begin
                    set_unit(u, bfa_pkg::CODE_FREE);
                    u++;
                end
            end
            frees++;
        end
        pending_q.push_back(res);
        return res;
    endfunction

    // compare one response transaction against the oldest prediction
    function void check_result(logic status, logic [bfa_pkg::OFFSET_W-1:0] offset);
        alloc_result_t exp;
        if (pending_q.size() == 0)
        begin
            $error("response with nothing outstanding: status %0d alloc_offset 0x%0h",
                   status, offset);
            mismatches++;
            return;
        end
        exp = pending_q.pop_front();
        results_seen++;
        if (status !== exp.status)
        begin
            $error("status: expected %0d, got %0d", exp.status, status);
            mismatches++;
        end
        if (offset !== exp.offset)
        begin
            $error("alloc_offset: expected 0x%0h, got 0x%0h", exp.offset, offset);
            mismatches++;
        end
    endfunction

endclass

module testbench;

    import bfa_pkg::*;

    localparam int RANDOM_ITEMS = 1080;
    // slowest transaction: 251 scanned and 251 marked map words, plus a long
    // receiver stall, a long sender gap and the 256-word fill after reset
    localparam int WATCHDOG_LIMIT = 5000;

    logic clk;
    logic rst_n;
    bit   no_idle;
    int   burst_left;

    bfa_req_if req_ch ();
    bfa_rsp_if rsp_ch ();

    alloc_scoreboard sb;

    logic [OFFSET_W-1:0] live_blocks [$];

    bitmap_first_fit_allocator_core #(
        .HEAP_ORDER (HEAP_ORDER)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req_ch),
        .rsp    (rsp_ch)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // one request transaction, bursts separated by random gaps
    task automatic issue_request(input logic cmd, input logic [REQ_BYTES_W-1:0] bytes,
                                 input logic [OFFSET_W-1:0] off);
        int             gap;
        alloc_result_t  pred;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            if (no_idle)
                gap = 0;
            else if ($urandom_range(0, 7) == 0)
                gap = $urandom_range(10, 40);
            else
                gap = $urandom_range(0, 4);
            repeat (gap)
            begin
                @(negedge clk);
                req_ch.valid <= 1'b0;
            end
        end
        burst_left--;
        @(negedge clk);
        req_ch.valid         <= 1'b1;
        req_ch.command       <= cmd;
        req_ch.request_bytes <= bytes;
        req_ch.free_offset   <= off;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        pred = sb.note_request(cmd, bytes, off);
        if (cmd == CMD_ALLOC && pred.status == STATUS_OK)
            live_blocks.push_back(pred.offset);
    endtask

    // receiver stalls on its own pattern
    initial
    begin : response_stall
        int   hold;
        logic rdy;
        hold = 0;
        rdy  = 1'b1;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold == 0)
            begin
                if (no_idle)
                begin
                    rdy  = 1'b1;
                    hold = 1;
                end
                else
                begin
                    rdy  = ($urandom_range(0, 2) != 0);
                    hold = rdy ? $urandom_range(1, 8) : $urandom_range(1, 15);
                end
            end
            hold--;
            rsp_ch.ready <= rdy;
        end
    end

    // response checker
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            sb.check_result(rsp_ch.status, rsp_ch.alloc_offset);
    end

    // watchdog on cycles without any accepted transaction
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
                (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("testbench NOT OK");
        $finish;
    end

    // stimulus
    initial
    begin : stimulus
        int                     n;
        int                     pick;
        int                     size_sel;
        int                     alloc_weight;
        int                     idx;
        logic [REQ_BYTES_W-1:0] bytes;
        logic [OFFSET_W-1:0]    off;

        sb = new();
        no_idle              = 1'b0;
        burst_left           = 0;
        alloc_weight         = 75;
        rst_n                = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.command       = CMD_ALLOC;
        req_ch.request_bytes = '0;
        req_ch.free_offset   = '0;

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // directed: size extremes, rounding, refusals
        issue_request(CMD_ALLOC, 17'd0, 16'hFFFF);
        issue_request(CMD_ALLOC, 17'd1, 16'h0000);
        issue_request(CMD_ALLOC, 17'd16, 16'h1234);
        issue_request(CMD_ALLOC, 17'd17, 16'h0000);
        issue_request(CMD_ALLOC, 17'h1FFFF, 16'h0000);
        issue_request(CMD_ALLOC, 17'd65536, 16'h0000);
        // unaligned free, then reuse of the hole
        issue_request(CMD_FREE, 17'h1FFFF, 16'h051F);
        issue_request(CMD_ALLOC, 17'd15, 16'h0000);
        // free mid-block, head of the rest, and an already free unit
        issue_request(CMD_FREE, 17'd0, 16'h0530);
        issue_request(CMD_FREE, 17'd0, 16'h0520);
        issue_request(CMD_FREE, 17'd0, 16'h0520);
        // free inside map area, reserved block and the last unit
        issue_request(CMD_FREE, 17'd0, 16'h0000);
        issue_request(CMD_FREE, 17'd0, 16'h0400);
        issue_request(CMD_FREE, 17'd0, 16'hFFFF);
        issue_request(CMD_FREE, 17'd0, 16'h0500);
        issue_request(CMD_FREE, 17'd0, 16'h0510);
        // all of the heap after the reserved block in one block, then full heap
        issue_request(CMD_ALLOC, 17'd64256, 16'h0000);
        issue_request(CMD_ALLOC, 17'd1, 16'h0000);
        // hole at the end of the map
        issue_request(CMD_FREE, 17'd0, 16'hFFF0);
        issue_request(CMD_ALLOC, 17'd16, 16'h0000);
        issue_request(CMD_FREE, 17'd0, 16'h0500);
        issue_request(CMD_FREE, 17'd0, 16'hFFF0);
        issue_request(CMD_ALLOC, 17'd64257, 16'h0000);
        live_blocks.delete();

        // random traffic in rounds alternating fill and drain pressure
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 100 == 0)
            begin
                alloc_weight = ((n / 100) % 2 == 0) ? 75 : 35;
                no_idle      = ((n / 100) % 4 == 3);
            end
            pick = $urandom_range(0, 99);
            if (pick >= 95)
            begin
                // noise: any command, any size, any offset
                issue_request(1'($urandom_range(0, 1)), 17'($urandom_range(0, 131071)),
                              16'($urandom));
            end
            else if (pick < alloc_weight || live_blocks.size() == 0)
            begin
                size_sel = $urandom_range(0, 99);
                if (size_sel < 70)
                    bytes = 17'($urandom_range(1, 256));
                else if (size_sel < 92)
                    bytes = 17'($urandom_range(257, 4096));
                else if (size_sel < 99)
                    bytes = 17'($urandom_range(4097, 32768));
                else
                    bytes = 17'($urandom_range(32769, 131071));
                issue_request(CMD_ALLOC, bytes, 16'($urandom));
            end
            else
            begin
                idx = $urandom_range(0, live_blocks.size() - 1);
                off = live_blocks[idx];
                live_blocks.delete(idx);
                issue_request(CMD_FREE, 17'($urandom),
                              off | 16'($urandom_range(0, 15)));
            end
        end

        // drain
        @(negedge clk);
        req_ch.valid <= 1'b0;
        no_idle = 1'b0;
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("covered %0d allocations (%0d refused) and %0d frees",
                 sb.allocs_ok + sb.allocs_refused, sb.allocs_refused, sb.frees);
        $display("%0d responses compared, %0d mismatches", sb.results_seen, sb.mismatches);
        if (sb.mismatches == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
